// ----- rtl/clip_endpoint_to_rect_assert.svh -----
// Assertion macros shared by the clipping block.
`ifndef CLIP_ENDPOINT_TO_RECT_ASSERT_SVH
`define CLIP_ENDPOINT_TO_RECT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CEP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clip_endpoint_to_rect assertion failed");

// Next-cycle implication, checked at every edge.
`define CEP_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("clip_endpoint_to_rect assertion failed");

`endif

// ----- rtl/cep_pkg.sv -----
// Shared types and constants of the endpoint clipping block.
package cep_pkg;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM = 2'd3;

   // Reset values of the rectangle edges.
   localparam int LEFT_RESET   = 0;
   localparam int RIGHT_RESET  = 600;
   localparam int TOP_RESET    = 0;
   localparam int BOTTOM_RESET = 350;

   // Flow control handed to each divider cell.
   typedef struct packed {
      logic valid;
      logic advance;
   } cep_flow_type;

endpackage

// ----- rtl/cep_div_cell.sv -----
// One restoring division step: develops one quotient bit per cell.
module cep_div_cell #(
   parameter int DVD_W = 32,
   parameter int DIV_W = 16,
   parameter int PAY_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cep_pkg::cep_flow_type   flow_in,
   input  logic [DIV_W-1:0]        rem_in,
   input  logic [DVD_W-1:0]        dvd_in,
   input  logic [DIV_W-1:0]        div_in,
   input  logic [PAY_W-1:0]        pay_in,
   output logic                    valid_out,
   output logic [DIV_W-1:0]        rem_out,
   output logic [DVD_W-1:0]        dvd_out,
   output logic [DIV_W-1:0]        div_out,
   output logic [PAY_W-1:0]        pay_out
);
   import cep_pkg::*;

   logic [DIV_W:0]   trial;
   logic             fits;
   logic [DIV_W-1:0] rem_in_next;
   logic             valid_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [DIV_W-1:0] div_ff;
   logic [PAY_W-1:0] pay_ff;

   // Bring down the next dividend bit and try to subtract the divisor.
   always_comb begin
      trial = {rem_in, dvd_in[DVD_W-1]};
      fits  = (trial >= {1'b0, div_in});
      if (fits) begin
         rem_in_next = DIV_W'(trial - {1'b0, div_in});
      end else begin
         rem_in_next = trial[DIV_W-1:0];
      end
   end

   // Valid bit of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (flow_in.advance) begin
         valid_ff <= flow_in.valid;
      end
   end

   // Partial remainder, shifting dividend and quotient, divisor and payload.
   always_ff @(posedge clock) begin
      if (flow_in.advance) begin
         rem_ff <= rem_in_next;
         dvd_ff <= {dvd_in[DVD_W-2:0], fits};
         div_ff <= div_in;
         pay_ff <= pay_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign dvd_out   = dvd_ff;
   assign div_out   = div_ff;
   assign pay_out   = pay_ff;

endmodule

// ----- rtl/cep_div_chain.sv -----
// Row of division cells giving quotient and remainder.
module cep_div_chain #(
   parameter int DVD_W = 32,
   parameter int DIV_W = 16,
   parameter int PAY_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             valid_in,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   input  logic [PAY_W-1:0] pay_in,
   output logic             valid_out,
   output logic [DVD_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder,
   output logic [PAY_W-1:0] pay_out
);
   import cep_pkg::*;

   logic             valid_w [DVD_W+1];
   logic [DIV_W-1:0] rem_w   [DVD_W+1];
   logic [DVD_W-1:0] dvd_w   [DVD_W+1];
   logic [DIV_W-1:0] div_w   [DVD_W+1];
   logic [PAY_W-1:0] pay_w   [DVD_W+1];

   // Head of the row starts with a zero remainder.
   assign valid_w[0] = valid_in;
   assign rem_w[0]   = '0;
   assign dvd_w[0]   = dividend;
   assign div_w[0]   = divisor;
   assign pay_w[0]   = pay_in;

   // One cell per quotient bit, each passing its work to the next.
   for (genvar i = 0; i < DVD_W; i++) begin : g_cell
      cep_flow_type flow;
      assign flow.valid   = valid_w[i];
      assign flow.advance = advance;
      cep_div_cell #(
         .DVD_W (DVD_W),
         .DIV_W (DIV_W),
         .PAY_W (PAY_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .flow_in   (flow),
         .rem_in    (rem_w[i]),
         .dvd_in    (dvd_w[i]),
         .div_in    (div_w[i]),
         .pay_in    (pay_w[i]),
         .valid_out (valid_w[i+1]),
         .rem_out   (rem_w[i+1]),
         .dvd_out   (dvd_w[i+1]),
         .div_out   (div_w[i+1]),
         .pay_out   (pay_w[i+1])
      );
   end

   assign valid_out = valid_w[DVD_W];
   assign quotient  = dvd_w[DVD_W];
   assign remainder = rem_w[DVD_W];
   assign pay_out   = pay_w[DVD_W];

endmodule

// ----- rtl/clip_endpoint_to_rect.sv -----
// Top level: clips a segment end point to the configured rectangle.
//
//  channel | direction | handshake              | contents
//  req     | in        | req_tvalid/req_tready  | start_x, start_y, free_x, free_y
//  rsp     | out       | rsp_tvalid/rsp_tready  | end_x, end_y
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One item is accepted per cycle unless rsp stalls. Path: stage 1 register, a row of
// 2*COORD_WIDTH division cells, stage 2 register, a second such row, output register.
// Reset clears all valid bits and loads the edge registers with their reset values.
// When a result waits on rsp, the whole pipeline holds and req_tready drops.
// Configuration writes are always taken, as csr_ready is tied high.
module clip_endpoint_to_rect #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, free_x, free_y from bit 0 up
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // end_x, end_y from bit 0 up
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cep_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_data
);
   import cep_pkg::*;
   `include "clip_endpoint_to_rect_assert.svh"

   localparam int W     = COORD_WIDTH;
   localparam int PW    = 2 * W;
   localparam int LW    = 2 * W + 2;
   localparam int RSP_W = ((2 * W + 7) / 8) * 8;

   typedef struct packed {
      logic [W-1:0] x1;
      logic [W-1:0] y1;
      logic [W-1:0] x2;
      logic [W-1:0] y2;
      logic [W-1:0] xa;
      logic         take;
      logic         neg;
   } s1_pay_type;

   typedef struct packed {
      logic [W-1:0] x1;
      logic [W-1:0] xa;
      logic [W-1:0] yo;
      logic         take;
      logic         neg;
   } s2_pay_type;

   localparam int P1_W = $bits(s1_pay_type);
   localparam int P2_W = $bits(s2_pay_type);

   function automatic logic [W-1:0] mag_of(input logic signed [W:0] v);
      logic signed [W:0] n;
      n = -v;
      return v[W] ? n[W-1:0] : v[W-1:0];
   endfunction

   logic [W-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic         advance;

   // Edge registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= W'(LEFT_RESET);
         right_ff  <= W'(RIGHT_RESET);
         top_ff    <= W'(TOP_RESET);
         bottom_ff <= W'(BOTTOM_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT:   left_ff   <= csr_data;
            CSR_RIGHT:  right_ff  <= csr_data;
            CSR_TOP:    top_ff    <= csr_data;
            CSR_BOTTOM: bottom_ff <= csr_data;
            default:    left_ff   <= left_ff;
         endcase
      end
   end

   // The pipeline moves whenever the output register can take a result.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Stage 1: pick the left or right edge and form the product for the first cut.
   logic [W-1:0]      in_x1, in_y1, in_x2, in_y2, edge1;
   logic signed [W:0] dx1, dy1, off1;
   logic              left1, right1;
   s1_pay_type        s1_pay_in;
   logic [PW-1:0]     s1_mag_in;
   logic              s1_valid_ff;
   s1_pay_type        s1_pay_ff;
   logic [PW-1:0]     s1_mag_ff;
   logic [W-1:0]      s1_den_ff, s1_den_in;

   always_comb begin
      in_x1  = req_tdata[W-1:0];
      in_y1  = req_tdata[2*W-1:W];
      in_x2  = req_tdata[3*W-1:2*W];
      in_y2  = req_tdata[4*W-1:3*W];
      dx1    = $signed({1'b0, in_x2}) - $signed({1'b0, in_x1});
      dy1    = $signed({1'b0, in_y2}) - $signed({1'b0, in_y1});
      left1  = in_x2 < left_ff;
      right1 = in_x2 > right_ff;
      edge1  = left1 ? left_ff : right_ff;
      off1   = $signed({1'b0, edge1}) - $signed({1'b0, in_x1});
      s1_mag_in      = {{W{1'b0}}, mag_of(off1)} * {{W{1'b0}}, mag_of(dy1)};
      s1_den_in      = mag_of(dx1);
      s1_pay_in.x1   = in_x1;
      s1_pay_in.y1   = in_y1;
      s1_pay_in.x2   = in_x2;
      s1_pay_in.y2   = in_y2;
      s1_pay_in.take = (dx1 != '0) && (left1 || right1);
      s1_pay_in.xa   = s1_pay_in.take ? edge1 : in_x2;
      s1_pay_in.neg  = (off1 != '0) && (dy1 != '0) && ((off1[W] ^ dy1[W]) ^ dx1[W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pay_ff <= s1_pay_in;
         s1_mag_ff <= s1_mag_in;
         s1_den_ff <= s1_den_in;
      end
   end

   // First division row.
   logic             c1_valid;
   logic [PW-1:0]    c1_quo;
   logic [W-1:0]     c1_rem;
   logic [P1_W-1:0]  c1_pay_bits;
   s1_pay_type       c1_pay;

   cep_div_chain #(.DVD_W(PW), .DIV_W(W), .PAY_W(P1_W)) u_chain1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (s1_valid_ff),
      .dividend  (s1_mag_ff),
      .divisor   (s1_den_ff),
      .pay_in    (s1_pay_ff),
      .valid_out (c1_valid),
      .quotient  (c1_quo),
      .remainder (c1_rem),
      .pay_out   (c1_pay_bits)
   );
   assign c1_pay = c1_pay_bits;

   // Stage 2: finish the first cut, pick top or bottom, form the second product.
   logic signed [LW-1:0] part1, yf, yn, top_x, bot_x;
   logic                 yfrac, below, beyond;
   logic signed [W:0]    dx2, dy2, off2;
   logic [W-1:0]         edge2;
   s2_pay_type           s2_pay_in;
   logic [PW-1:0]        s2_mag_in;
   logic [W-1:0]         s2_den_in;
   logic                 s2_valid_ff;
   s2_pay_type           s2_pay_ff;
   logic [PW-1:0]        s2_mag_ff;
   logic [W-1:0]         s2_den_ff;

   always_comb begin
      yfrac = c1_pay.take && (c1_rem != '0);
      part1 = c1_pay.neg ? -($signed({2'b00, c1_quo}) + LW'(c1_rem != '0))
                         : $signed({2'b00, c1_quo});
      yf    = c1_pay.take ? ($signed({{(W+2){1'b0}}, c1_pay.y1}) + part1)
                          : $signed({{(W+2){1'b0}}, c1_pay.y2});
      top_x = $signed({{(W+2){1'b0}}, top_ff});
      bot_x = $signed({{(W+2){1'b0}}, bottom_ff});
      dx2   = $signed({1'b0, c1_pay.x2}) - $signed({1'b0, c1_pay.x1});
      dy2   = $signed({1'b0, c1_pay.y2}) - $signed({1'b0, c1_pay.y1});
      below  = yf < top_x;
      beyond = (yf > bot_x) || ((yf == bot_x) && yfrac);
      edge2  = below ? top_ff : bottom_ff;
      off2   = $signed({1'b0, edge2}) - $signed({1'b0, c1_pay.y1});
      s2_pay_in.take = (dy2 != '0) && (below || beyond);
      s2_pay_in.neg  = (off2 != '0) && (dx2 != '0) && ((off2[W] ^ dx2[W]) ^ dy2[W]);
      s2_pay_in.x1   = c1_pay.x1;
      s2_pay_in.xa   = c1_pay.xa;
      // Final y clamp: raise to top, then lower to bottom.
      yn = s2_pay_in.take ? $signed({{(W+2){1'b0}}, edge2}) : yf;
      if (yn < top_x) begin
         yn = top_x;
      end
      if (yn > bot_x) begin
         yn = bot_x;
      end
      s2_pay_in.yo = yn[W-1:0];
      s2_mag_in    = {{W{1'b0}}, mag_of(off2)} * {{W{1'b0}}, mag_of(dx2)};
      s2_den_in    = mag_of(dy2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= c1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pay_ff <= s2_pay_in;
         s2_mag_ff <= s2_mag_in;
         s2_den_ff <= s2_den_in;
      end
   end

   // Second division row.
   logic             c2_valid;
   logic [PW-1:0]    c2_quo;
   logic [W-1:0]     c2_rem;
   logic [P2_W-1:0]  c2_pay_bits;
   s2_pay_type       c2_pay;

   cep_div_chain #(.DVD_W(PW), .DIV_W(W), .PAY_W(P2_W)) u_chain2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (s2_valid_ff),
      .dividend  (s2_mag_ff),
      .divisor   (s2_den_ff),
      .pay_in    (s2_pay_ff),
      .valid_out (c2_valid),
      .quotient  (c2_quo),
      .remainder (c2_rem),
      .pay_out   (c2_pay_bits)
   );
   assign c2_pay = c2_pay_bits;

   // Stage 3: finish the second cut and clamp x into the rectangle.
   logic signed [LW-1:0] part2, xn, left_x, right_x;
   logic [W-1:0]         end_x_in;
   logic                 rsp_valid_ff;
   logic [W-1:0]         end_x_ff, end_y_ff;

   always_comb begin
      left_x  = $signed({{(W+2){1'b0}}, left_ff});
      right_x = $signed({{(W+2){1'b0}}, right_ff});
      part2 = c2_pay.neg ? -($signed({2'b00, c2_quo}) + LW'(c2_rem != '0))
                         : $signed({2'b00, c2_quo});
      xn = c2_pay.take ? ($signed({{(W+2){1'b0}}, c2_pay.x1}) + part2)
                       : $signed({{(W+2){1'b0}}, c2_pay.xa});
      if (xn < left_x) begin
         xn = left_x;
      end
      if (xn > right_x) begin
         xn = right_x;
      end
      end_x_in = xn[W-1:0];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         end_x_ff <= end_x_in;
         end_y_ff <= c2_pay.yo;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({end_y_ff, end_x_ff});

   // Checks on the pipeline and the clamp.
   `CEP_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `CEP_ASSERT_NEXT(a_reset_empties_output, clock, reset, !rsp_tvalid)
   `CEP_ASSERT_NOW(a_x_in_rect, clock, reset, rsp_tvalid && (left_ff <= right_ff),
      (end_x_ff >= left_ff) && (end_x_ff <= right_ff))
   `CEP_ASSERT_NOW(a_y_in_rect, clock, reset, rsp_tvalid && (top_ff <= bottom_ff),
      (end_y_ff >= top_ff) && (end_y_ff <= bottom_ff))

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the endpoint clipping block.
`timescale 1ns / 1ps

module tb;
   import cep_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = 4 * CW + 3;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [CW-1:0] free_y;
      logic [CW-1:0] free_x;
      logic [CW-1:0] start_y;
      logic [CW-1:0] start_x;
   } segment_t;

   typedef struct packed {
      logic [CW-1:0] end_y;
      logic [CW-1:0] end_x;
   } point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LEFT;
   logic [CW-1:0] csr_data = '0;

   clip_endpoint_to_rect #(.COORD_WIDTH(CW)) DUT (.*);

   always #6 clock = ~clock;

   // Rectangle as the testbench believes it is programmed.
   longint rect_left, rect_right, rect_top, rect_bottom;

   segment_t pending_segments[$];
   point_t clipped_points[$];
   int error_count = 0;
   int sent_count = 0;
   int recv_count = 0;
   int send_idle_pct = 38;
   int recv_idle_pct = 78;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   bit req_accepted = 0;
   bit done_sending = 0;

   // floor(base + off * num / den); rem reports a nonzero remainder.
   function automatic longint edge_cross(longint base, longint off, longint num,
                                         longint den, output bit rem);
      longint mag, d, q;
      bit neg;
      neg = ((off < 0) != (num < 0)) != (den < 0);
      mag = (off < 0 ? -off : off) * (num < 0 ? -num : num);
      d = den < 0 ? -den : den;
      q = mag / d;
      rem = (mag % d) != 0;
      if (mag == 0) neg = 0;
      if (q > (64'sd1 << 34)) q = 64'sd1 << 34;
      return neg ? base - (q + rem) : base + q;
   endfunction

   function automatic point_t clip_point(segment_t s);
      longint x1, y1, x2, y2, dx, dy, xf, yf;
      bit yrem, xrem;
      point_t p;
      x1 = s.start_x; y1 = s.start_y; x2 = s.free_x; y2 = s.free_y;
      yrem = 0;
      if (x2 >= rect_left && x2 <= rect_right && y2 >= rect_top && y2 <= rect_bottom) begin
         p.end_x = s.free_x;
         p.end_y = s.free_y;
         return p;
      end
      dx = x2 - x1; dy = y2 - y1; xf = x2; yf = y2;
      // Move onto the crossed side edge first.
      if (dx != 0) begin
         if (x2 < rect_left) begin
            yf = edge_cross(y1, rect_left - x1, dy, dx, yrem);
            xf = rect_left;
         end else if (x2 > rect_right) begin
            yf = edge_cross(y1, rect_right - x1, dy, dx, yrem);
            xf = rect_right;
         end
      end
      // Then onto the top or bottom edge, honoring a fractional y.
      if (dy != 0) begin
         if (yf < rect_top) begin
            xf = edge_cross(x1, rect_top - y1, dx, dy, xrem);
            yf = rect_top;
         end else if (yf > rect_bottom || (yf == rect_bottom && yrem)) begin
            xf = edge_cross(x1, rect_bottom - y1, dx, dy, xrem);
            yf = rect_bottom;
         end
      end
      if (xf < rect_left) xf = rect_left;
      if (xf > rect_right) xf = rect_right;
      if (yf < rect_top) yf = rect_top;
      if (yf > rect_bottom) yf = rect_bottom;
      p.end_x = xf[CW-1:0];
      p.end_y = yf[CW-1:0];
      return p;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, recv_count);
      error_count++;
   endtask

   // Driver: one segment transfer offered per cycle unless idling or holding an unaccepted offer.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_accepted) begin
            if (pending_segments.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= pending_segments.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: ready unless idling or inside a long hold.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Monitor: predict on accepted segments, check accepted points.
   always @(posedge clock) begin
      point_t got, want;
      if (!reset) begin
         quiet_cycles <= ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ?
                         0 : quiet_cycles + 1;
         req_accepted <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            clipped_points.push_back(clip_point(segment_t'(req_tdata)));
            sent_count <= sent_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            recv_count <= recv_count + 1;
            got = point_t'(rsp_tdata);
            if (clipped_points.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               want = clipped_points.pop_front();
               if (got.end_x !== want.end_x) report_mismatch("end_x", got.end_x, want.end_x);
               if (got.end_y !== want.end_y) report_mismatch("end_y", got.end_y, want.end_y);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer at all.
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout with %0d results outstanding", clipped_points.size());
         $display("tb: errors");
         $finish;
      end
   end

   task automatic write_edge(logic [CSR_IDX_W-1:0] idx, longint value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CW-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LEFT:   rect_left = value;
         CSR_RIGHT:  rect_right = value;
         CSR_TOP:    rect_top = value;
         default:    rect_bottom = value;
      endcase
   endtask

   task automatic set_rect(longint l, longint r, longint t, longint b);
      write_edge(CSR_LEFT, l);
      write_edge(CSR_RIGHT, r);
      write_edge(CSR_TOP, t);
      write_edge(CSR_BOTTOM, b);
   endtask

   task automatic drain();
      while (pending_segments.size() > 0 || clipped_points.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] near_coord(longint lo, longint hi);
      longint v;
      case ($urandom_range(5))
         0: v = lo - $urandom_range(3);
         1: v = hi + $urandom_range(3);
         2: v = $urandom_range(lo, hi);
         3: v = $urandom_range(65535);
         4: v = $urandom_range(1) ? 0 : 65535;
         default: v = $urandom_range(lo, hi + 200);
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[CW-1:0];
   endfunction

   // Mostly segments from inside the rectangle toward near or far points.
   task automatic queue_random(int count);
      segment_t s;
      longint lo_x, hi_x, lo_y, hi_y;
      repeat (count) begin
         lo_x = rect_left < rect_right ? rect_left : rect_right;
         hi_x = rect_left < rect_right ? rect_right : rect_left;
         lo_y = rect_top < rect_bottom ? rect_top : rect_bottom;
         hi_y = rect_top < rect_bottom ? rect_bottom : rect_top;
         if ($urandom_range(9) < 7) begin
            s.start_x = $urandom_range(lo_x, hi_x);
            s.start_y = $urandom_range(lo_y, hi_y);
         end else begin
            s.start_x = near_coord(lo_x, hi_x);
            s.start_y = near_coord(lo_y, hi_y);
         end
         s.free_x = near_coord(lo_x, hi_x);
         s.free_y = near_coord(lo_y, hi_y);
         if ($urandom_range(15) == 0) s.free_x = s.start_x;
         if ($urandom_range(15) == 0) s.free_y = s.start_y;
         pending_segments.push_back(s);
      end
   endtask

   function automatic segment_t seg(longint sx, longint sy, longint fx, longint fy);
      segment_t s;
      s.start_x = sx; s.start_y = sy; s.free_x = fx; s.free_y = fy;
      return s;
   endfunction

   initial begin
      rect_left = LEFT_RESET; rect_right = RIGHT_RESET;
      rect_top = TOP_RESET; rect_bottom = BOTTOM_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed cases on the reset rectangle.
      pending_segments.push_back(seg(100, 100, 600, 350));
      pending_segments.push_back(seg(100, 100, 0, 0));
      pending_segments.push_back(seg(100, 100, 601, 200));
      pending_segments.push_back(seg(100, 100, 200, 351));
      pending_segments.push_back(seg(300, 100, 300, 65535));
      pending_segments.push_back(seg(100, 200, 65535, 200));
      pending_segments.push_back(seg(300, 175, 65535, 65535));
      pending_segments.push_back(seg(0, 0, 65535, 65535));
      pending_segments.push_back(seg(65535, 65535, 0, 0));
      pending_segments.push_back(seg(1, 2, 700, 351));
      pending_segments.push_back(seg(0, 349, 65535, 351));
      pending_segments.push_back(seg(700, 400, 800, 500));
      pending_segments.push_back(seg(65535, 0, 65535, 65535));
      drain();

      // Inverted rectangle: nothing is inside.
      set_rect(500, 100, 300, 50);
      pending_segments.push_back(seg(300, 200, 300, 200));
      pending_segments.push_back(seg(0, 0, 65535, 65535));
      pending_segments.push_back(seg(65535, 0, 0, 65535));
      drain();

      send_idle_pct = 38; recv_idle_pct = 78;
      set_rect(0, 65535, 0, 65535);
      queue_random(150);
      drain();
      set_rect(1000, 1003, 2000, 2001);
      queue_random(200);
      drain();

      send_idle_pct = 78; recv_idle_pct = 38;
      set_rect(65535, 65535, 0, 0);
      queue_random(150);
      drain();
      set_rect(12345, 40000, 777, 50000);
      queue_random(250);
      drain();

      // Long receiver hold while the sender keeps offering.
      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random(300);
      @(negedge clock);
      hold_cycles = 400;
      drain();
      set_rect(LEFT_RESET, RIGHT_RESET, TOP_RESET, BOTTOM_RESET);
      queue_random(200);
      drain();

      $display("Checked %0d clipped end points across six rectangle settings,", recv_count);
      $display("including inverted, degenerate and full-range edges and a long output stall.");
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
